// File: hdl/oss_pkg.sv
// Shared constants, types and helpers of the overlapping substring search unit.
package oss_pkg;

    localparam int MAX_KEYWORD   = 16;
    localparam int OFFSET_BITS   = 24;
    localparam int PAGE_BITS     = 16;
    localparam int KEY_REG_BYTES = 16;
    localparam int LEN_BITS      = 5;
    localparam int HIT_BITS      = 10;
    localparam int SEEN_BITS     = OFFSET_BITS + 1;
    localparam int MARK_CNT_BITS = $clog2(MAX_KEYWORD + 1);
    localparam int CFG_DATA_BITS = 64;
    localparam int CFG_IDX_BITS  = 2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_KEY_LOW   = 2'd0,
        CFG_KEY_HIGH  = 2'd1,
        CFG_KEY_LEN   = 2'd2,
        CFG_HIT_LIMIT = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_DATA_BITS-1:0] key_low;
        logic [CFG_DATA_BITS-1:0] key_high;
        logic [LEN_BITS-1:0]      key_len;
        logic [HIT_BITS-1:0]      hit_limit;
    } t_cfg;

    // Window and counters after one text byte has been taken in.
    typedef struct packed {
        logic [MAX_KEYWORD-1:0][7:0] bytes;
        logic [MAX_KEYWORD-1:0]      marks;
        logic [SEEN_BITS-1:0]        seen;
        logic [PAGE_BITS-1:0]        pages;
        logic                        first;
        logic                        last;
    } t_win;

    // Keyword byte at a given position; zero outside the two key registers.
    function automatic logic [7:0] key_byte(t_cfg cfg, int idx);
        logic [7:0] res;
        res = 8'd0;
        if (idx >= 0 && idx < 8) begin
            res = cfg.key_low[8*idx +: 8];
        end else if (idx >= 8 && idx < KEY_REG_BYTES) begin
            res = cfg.key_high[8*(idx-8) +: 8];
        end
        return res;
    endfunction

endpackage

// File: hdl/oss_text_if.sv
// Request channel carrying one text byte and its flags.
interface oss_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       page_begin;
    logic       first_of_text;
    logic       last_of_text;

    modport source (output valid, output text_byte, output page_begin,
                    output first_of_text, output last_of_text, input ready);
    modport sink   (input valid, input text_byte, input page_begin,
                    input first_of_text, input last_of_text, output ready);
endinterface

// File: hdl/oss_hit_if.sv
// Result channel carrying one hit or done report.
interface oss_hit_if;
    logic                          valid;
    logic                          ready;
    logic                          hit_found;
    logic [oss_pkg::OFFSET_BITS-1:0] hit_offset;
    logic [oss_pkg::PAGE_BITS-1:0]   hit_page;
    logic                          search_done;
    logic [oss_pkg::HIT_BITS-1:0]    hit_total;

    modport source (output valid, output hit_found, output hit_offset, output hit_page,
                    output search_done, output hit_total, input ready);
    modport sink   (input valid, input hit_found, input hit_offset, input hit_page,
                    input search_done, input hit_total, output ready);
endinterface

// File: hdl/overlapping_substring_search_unit.sv
// Top level of the overlapping substring search unit.
// A text byte passes through the window register and then the result register
// before its result can be taken.
// Throughput: one text byte per cycle; the input register and the result
// register form a two-stage pipeline that stalls only when a result is not taken.
// Reset (synchronous, active low) clears the keyword, length and hit limit
// registers, the byte and page mark windows, and all counters.
module overlapping_substring_search_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    oss_text_if.sink                             i_text,
    oss_hit_if.source                            o_hit,
    input  logic                                 i_cfg_we,
    input  logic [oss_pkg::CFG_IDX_BITS-1:0]     i_cfg_idx,
    input  logic [oss_pkg::CFG_DATA_BITS-1:0]    i_cfg_data
);

    oss_pkg::t_cfg r_cfg;
    oss_pkg::t_win w_win;
    logic          w_valid;
    logic          w_adv;

    // Write the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (oss_pkg::t_cfg_idx'(i_cfg_idx))
                oss_pkg::CFG_KEY_LOW: begin
                    r_cfg.key_low <= i_cfg_data;
                end
                oss_pkg::CFG_KEY_HIGH: begin
                    r_cfg.key_high <= i_cfg_data;
                end
                oss_pkg::CFG_KEY_LEN: begin
                    r_cfg.key_len <= i_cfg_data[oss_pkg::LEN_BITS-1:0];
                end
                oss_pkg::CFG_HIT_LIMIT: begin
                    r_cfg.hit_limit <= i_cfg_data[oss_pkg::HIT_BITS-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    oss_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_text  (i_text),
        .i_adv   (w_adv),
        .o_valid (w_valid),
        .o_win   (w_win)
    );

    oss_match u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (w_valid),
        .i_win   (w_win),
        .o_adv   (w_adv),
        .o_hit   (o_hit)
    );

endmodule

// File: hdl/oss_window.sv
// Input stage: byte window, page mark window and saturating counters.
module oss_window (
    input  logic            i_clk,
    input  logic            i_rst_n,
    oss_text_if.sink        i_text,
    input  logic            i_adv,
    output logic            o_valid,
    output oss_pkg::t_win   o_win
);

    localparam logic [oss_pkg::SEEN_BITS-1:0] SEEN_MAX = '1;
    localparam logic [oss_pkg::PAGE_BITS-1:0] PAGE_MAX = '1;

    oss_pkg::t_win r_win;
    oss_pkg::t_win n_win;
    logic          r_valid;
    logic          w_accept;

    assign i_text.ready = !r_valid || i_adv;
    assign w_accept     = i_text.valid && i_text.ready;
    assign o_valid      = r_valid;
    assign o_win        = r_win;

    // Shift the new byte in, clearing the search first when a text starts
    always_comb begin
        logic [oss_pkg::MAX_KEYWORD-1:0][7:0] base_bytes;
        logic [oss_pkg::MAX_KEYWORD-1:0]      base_marks;
        logic [oss_pkg::SEEN_BITS-1:0]        base_seen;
        logic [oss_pkg::PAGE_BITS-1:0]        base_pages;
        base_bytes = i_text.first_of_text ? '0 : r_win.bytes;
        base_marks = i_text.first_of_text ? '0 : r_win.marks;
        base_seen  = i_text.first_of_text ? '0 : r_win.seen;
        base_pages = i_text.first_of_text ? '0 : r_win.pages;
        n_win.bytes[0] = i_text.text_byte;
        n_win.marks[0] = i_text.page_begin;
        for (int p = 1; p < oss_pkg::MAX_KEYWORD; p++) begin
            n_win.bytes[p] = base_bytes[p-1];
            n_win.marks[p] = base_marks[p-1];
        end
        n_win.seen  = (base_seen != SEEN_MAX) ? base_seen + 1'b1 : base_seen;
        n_win.pages = (i_text.page_begin && base_pages != PAGE_MAX) ?
                      base_pages + 1'b1 : base_pages;
        n_win.first = i_text.first_of_text;
        n_win.last  = i_text.last_of_text;
    end

    // Hold the window state and the stage valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_win <= n_win;
            end
            if (w_accept) begin
                r_valid <= 1'b1;
            end else if (i_adv) begin
                r_valid <= 1'b0;
            end
        end
    end

endmodule

// File: hdl/oss_match.sv
// Match stage: window compare, page and offset of the hit, hit count, result register.
module oss_match (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  oss_pkg::t_cfg   i_cfg,
    input  logic            i_valid,
    input  oss_pkg::t_win   i_win,
    output logic            o_adv,
    oss_hit_if.source       o_hit
);

    localparam int DIFF_BITS = oss_pkg::PAGE_BITS + oss_pkg::MARK_CNT_BITS;

    logic                            r_o_valid;
    logic                            r_found;
    logic [oss_pkg::OFFSET_BITS-1:0] r_offset;
    logic [oss_pkg::PAGE_BITS-1:0]   r_page;
    logic                            r_done;
    logic [oss_pkg::HIT_BITS-1:0]    r_total;
    logic [oss_pkg::HIT_BITS-1:0]    r_hits;
    logic [oss_pkg::HIT_BITS-1:0]    n_hits;

    logic                              w_hit;
    logic                              w_produce;
    logic [oss_pkg::HIT_BITS-1:0]      w_hcur;
    logic [oss_pkg::SEEN_BITS-1:0]     w_start;
    logic [oss_pkg::PAGE_BITS-1:0]     w_page;

    // Compare the window with the keyword and work out start and page
    always_comb begin
        int                                k;
        logic                              len_ok;
        logic                              enough;
        logic                              eq;
        logic [oss_pkg::MARK_CNT_BITS-1:0] later;
        logic [DIFF_BITS-1:0]              pages_w;
        logic [DIFF_BITS-1:0]              later_w;
        logic [DIFF_BITS-1:0]              cnt;
        k      = int'(i_cfg.key_len);
        len_ok = (k != 0) && (k <= oss_pkg::MAX_KEYWORD) && (k <= oss_pkg::KEY_REG_BYTES);
        enough = i_win.seen >= oss_pkg::SEEN_BITS'(i_cfg.key_len);
        eq     = 1'b1;
        later  = '0;
        for (int p = 0; p < oss_pkg::MAX_KEYWORD; p++) begin
            if (p < k && i_win.bytes[p] != oss_pkg::key_byte(i_cfg, k - 1 - p)) begin
                eq = 1'b0;
            end
            if (p + 1 < k) begin
                later = later + oss_pkg::MARK_CNT_BITS'(i_win.marks[p]);
            end
        end
        w_start = i_win.seen - oss_pkg::SEEN_BITS'(i_cfg.key_len);
        pages_w = DIFF_BITS'(i_win.pages);
        later_w = DIFF_BITS'(later);
        cnt     = (pages_w > later_w) ? pages_w - later_w : '0;
        w_page  = (cnt != '0) ? oss_pkg::PAGE_BITS'(cnt - 1'b1) : '0;
        w_hcur  = i_win.first ? '0 : r_hits;
        w_hit   = len_ok && enough && (w_hcur < i_cfg.hit_limit) && eq &&
                  !w_start[oss_pkg::SEEN_BITS-1];
        w_produce = w_hit || i_win.last;
        n_hits    = w_hcur + oss_pkg::HIT_BITS'(w_hit);
    end

    assign o_adv = i_valid && (!r_o_valid || o_hit.ready);

    // Load the result register when the stage advances, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_hits    <= '0;
        end else begin
            if (o_adv) begin
                r_o_valid <= w_produce;
                r_hits    <= n_hits;
            end else if (o_hit.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload of the result register
    always_ff @(posedge i_clk) begin
        if (o_adv) begin
            r_found  <= w_hit;
            r_offset <= w_hit ? w_start[oss_pkg::OFFSET_BITS-1:0] : '0;
            r_page   <= w_hit ? w_page : '0;
            r_done   <= i_win.last;
            r_total  <= n_hits;
        end
    end

    assign o_hit.valid       = r_o_valid;
    assign o_hit.hit_found   = r_found;
    assign o_hit.hit_offset  = r_offset;
    assign o_hit.hit_page    = r_page;
    assign o_hit.search_done = r_done;
    assign o_hit.hit_total   = r_total;

    // A result without a hit only ever reports the end of the text
    a_nohit_is_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_found) |-> r_done)
        else $error("result with neither hit nor done");

    // A reported hit counts itself
    a_hit_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_found) |-> (r_total != '0))
        else $error("hit reported with zero hit total");

    // The hit count grows by at most one per advanced byte
    a_hits_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_adv && !i_win.first) |=> (r_hits == $past(r_hits) ||
                                     r_hits == $past(r_hits) + 1'b1))
        else $error("hit count jumped");

    // A stalled result keeps its payload
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !o_hit.ready) |=> ($stable(r_total) && $stable(r_offset)))
        else $error("stalled result changed");

endmodule

// File: tb/tb_oss_checker.sv
// Scoreboard for the substring search unit: predicts hit and done reports and compares them.
module tb_oss_checker
    import oss_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    oss_text_if                      i_text,
    oss_hit_if                       i_hit,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output int                       o_errors,
    output int                       o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic                   found;
        logic [OFFSET_BITS-1:0] offset;
        logic [PAGE_BITS-1:0]   page;
        logic                   done;
        logic [HIT_BITS-1:0]    total;
    } t_hit_rpt;

    t_hit_rpt hit_reports_due[$];

    // Search state as seen by the predictor
    logic [7:0]           win_byte [MAX_KEYWORD];
    logic                 win_mark [MAX_KEYWORD];
    logic [SEEN_BITS-1:0] seen_cnt;
    logic [PAGE_BITS-1:0] page_cnt;
    logic [HIT_BITS-1:0]  hit_cnt;

    // Shadow copy of the search registers
    logic [63:0]          kw_low;
    logic [63:0]          kw_high;
    logic [LEN_BITS-1:0]  kw_len;
    logic [HIT_BITS-1:0]  hit_cap;

    int err_count = 0;

    function automatic logic [7:0] keyword_at(int j);
        logic [7:0] res;
        res = 8'd0;
        if (j < 8) begin
            res = kw_low[8*j +: 8];
        end else if (j < 16) begin
            res = kw_high[8*(j-8) +: 8];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (err_count < 40) begin
            $display("MISMATCH @%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
        end
        err_count++;
    endtask

    task automatic clear_search();
        for (int i = 0; i < MAX_KEYWORD; i++) begin
            win_byte[i] = 8'd0;
            win_mark[i] = 1'b0;
        end
        seen_cnt = '0;
        page_cnt = '0;
        hit_cnt  = '0;
    endtask

    // Take one text byte into the window and queue the report it causes, if any
    task automatic search_step(input logic [7:0] b, input logic mark,
                               input logic first, input logic last);
        t_hit_rpt             rpt;
        logic                 match;
        int                   k;
        int                   later;
        logic [SEEN_BITS-1:0] start;
        logic [PAGE_BITS-1:0] cnt;
        if (first) begin
            clear_search();
        end
        for (int i = MAX_KEYWORD - 1; i > 0; i--) begin
            win_byte[i] = win_byte[i-1];
            win_mark[i] = win_mark[i-1];
        end
        win_byte[0] = b;
        win_mark[0] = mark;
        if (seen_cnt != '1) begin
            seen_cnt++;
        end
        if (mark && page_cnt != '1) begin
            page_cnt++;
        end

        rpt = '0;
        k   = int'(kw_len);
        if (k != 0 && k <= MAX_KEYWORD && k <= KEY_REG_BYTES &&
            seen_cnt >= SEEN_BITS'(k) && hit_cnt < hit_cap) begin
            match = 1'b1;
            for (int j = 0; j < k; j++) begin
                if (win_byte[k-1-j] != keyword_at(j)) begin
                    match = 1'b0;
                end
            end
            start = seen_cnt - SEEN_BITS'(k);
            // Drop a match whose start offset does not fit the offset field
            if (match && !start[SEEN_BITS-1]) begin
                later = 0;
                for (int j = 0; j + 1 < k; j++) begin
                    later += int'(win_mark[j]);
                end
                cnt = (int'(page_cnt) > later) ? page_cnt - PAGE_BITS'(later) : '0;
                rpt.found  = 1'b1;
                rpt.offset = start[OFFSET_BITS-1:0];
                rpt.page   = (cnt != '0) ? cnt - 1'b1 : '0;
                hit_cnt++;
            end
        end
        rpt.done  = last;
        rpt.total = hit_cnt;
        if (rpt.found || last) begin
            hit_reports_due.push_back(rpt);
        end
    endtask

    task automatic check_report();
        t_hit_rpt want;
        if (hit_reports_due.size() == 0) begin
            report_mismatch("result with no request pending, offset", i_hit.hit_offset, 0);
        end else begin
            want = hit_reports_due.pop_front();
            if (i_hit.hit_found !== want.found)
                report_mismatch("hit_found", i_hit.hit_found, want.found);
            if (i_hit.hit_offset !== want.offset)
                report_mismatch("hit_offset", i_hit.hit_offset, want.offset);
            if (i_hit.hit_page !== want.page)
                report_mismatch("hit_page", i_hit.hit_page, want.page);
            if (i_hit.search_done !== want.done)
                report_mismatch("search_done", i_hit.search_done, want.done);
            if (i_hit.hit_total !== want.total)
                report_mismatch("hit_total", i_hit.hit_total, want.total);
        end
    endtask

    // Retire results before taking the request of the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_search();
            kw_low  = '0;
            kw_high = '0;
            kw_len  = '0;
            hit_cap = '0;
            hit_reports_due.delete();
        end else begin
            if (i_hit.valid && i_hit.ready) begin
                check_report();
            end
            if (i_text.valid && i_text.ready) begin
                search_step(i_text.text_byte, i_text.page_begin,
                            i_text.first_of_text, i_text.last_of_text);
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_KEY_LOW:   kw_low  = i_cfg_data;
                    CFG_KEY_HIGH:  kw_high = i_cfg_data;
                    CFG_KEY_LEN:   kw_len  = i_cfg_data[LEN_BITS-1:0];
                    CFG_HIT_LIMIT: hit_cap = i_cfg_data[HIT_BITS-1:0];
                    default: ;
                endcase
            end
        end
        o_errors  <= err_count;
        o_pending <= hit_reports_due.size();
    end

endmodule

// File: tb/tb_overlapping_substring_search_unit.sv
// Stimulus and verdict for the overlapping substring search unit.
module tb_overlapping_substring_search_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import oss_pkg::*;

    localparam int RUN_ITEMS   = 1300;
    localparam int CYCLE_LIMIT = 1_000_000;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    int   chk_errors;
    int   chk_pending;
    int   cycle_cnt = 0;
    int   random_items = 0;
    bit   idle_on = 1'b1;
    logic [7:0] kw [MAX_KEYWORD];

    oss_text_if text_ch();
    oss_hit_if  hit_ch();

    overlapping_substring_search_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_text     (text_ch),
        .o_hit      (hit_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    tb_oss_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_text     (text_ch),
        .i_hit      (hit_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_errors   (chk_errors),
        .o_pending  (chk_pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Mostly no gap, sometimes a short one, rarely a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Give up after a generous number of cycles
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // Stall the result side at random
    initial begin
        int hold;
        hold = 0;
        hit_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n || hold > 0) begin
                hit_ch.ready <= 1'b0;
                if (hold > 0) hold--;
            end else begin
                hit_ch.ready <= 1'b1;
                if (idle_on) hold = pick_gap();
            end
        end
    end

    // Present one request and hold it until it is taken
    task automatic push_text(input logic [7:0] b, input logic mark,
                             input logic first, input logic last);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0) begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        text_ch.valid         <= 1'b1;
        text_ch.text_byte     <= b;
        text_ch.page_begin    <= mark;
        text_ch.first_of_text <= first;
        text_ch.last_of_text  <= last;
        do @(posedge i_clk); while (!text_ch.ready);
    endtask

    // Drop valid and wait for every due report, then for the pipeline to empty
    task automatic wait_drained();
        text_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_search_regs(input logic [LEN_BITS-1:0] len,
                                    input logic [HIT_BITS-1:0] limit,
                                    input logic [127:0] key, input bit noisy);
        logic [63:0] len_word;
        logic [63:0] limit_word;
        wait_drained();
        for (int j = 0; j < MAX_KEYWORD; j++) begin
            kw[j] = key[8*j +: 8];
        end
        // Junk above the field width must be ignored
        len_word   = noisy ? {$urandom, $urandom} : '0;
        limit_word = noisy ? {$urandom, $urandom} : '0;
        len_word[LEN_BITS-1:0]   = len;
        limit_word[HIT_BITS-1:0] = limit;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_KEY_LOW;
        i_cfg_data <= key[63:0];
        @(posedge i_clk);
        i_cfg_idx  <= CFG_KEY_HIGH;
        i_cfg_data <= key[127:64];
        @(posedge i_clk);
        i_cfg_idx  <= CFG_KEY_LEN;
        i_cfg_data <= len_word;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_HIT_LIMIT;
        i_cfg_data <= limit_word;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Send up to 16 bytes, byte i in data[8i+7:8i], its page mark in marks[i]
    task automatic send_text(input logic [127:0] data, input logic [15:0] marks, input int n,
                             input logic with_first, input logic with_last);
        for (int i = 0; i < n; i++) begin
            push_text(data[8*i +: 8], marks[i], with_first && i == 0, with_last && i == n - 1);
        end
    endtask

    task automatic run_directed();
        // Reset values: empty keyword, extremes of the byte
        send_text(128'hFF00, 16'h0001, 2, 1'b1, 1'b1);
        // Overlapping hits, one on the last byte, then bytes after the last
        load_search_regs(5'd3, 10'd1023, 128'h414241, 1'b0);
        send_text(128'h4142414241, 16'h0009, 5, 1'b1, 1'b1);
        send_text(128'h4142, 16'h0000, 2, 1'b0, 1'b1);
        // Zero keyword against a cleared window: too few bytes, then a hit
        load_search_regs(5'd2, 10'd1023, 128'h0, 1'b0);
        send_text(128'h00, 16'h0000, 1, 1'b1, 1'b1);
        send_text(128'h00, 16'h0000, 1, 1'b0, 1'b1);
        // Hit limit of one, dense page marks
        load_search_regs(5'd2, 10'd1, 128'h00FF, 1'b0);
        send_text(128'h00FF00FF, 16'h000F, 4, 1'b1, 1'b1);
        // Keyword lengths past the maximum find nothing
        load_search_regs(5'd31, 10'd1023, 128'h414241, 1'b0);
        send_text(128'h414241, 16'h0000, 3, 1'b1, 1'b1);
        load_search_regs(5'd17, 10'd1023, 128'h414241, 1'b0);
        send_text(128'h414241, 16'h0000, 3, 1'b1, 1'b1);
        // Full-length keyword
        load_search_regs(5'd16, 10'd1023, {64'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 1'b0);
        send_text({64'h0, 64'hFFFF_FFFF_FFFF_FFFF}, 16'h8001, 16, 1'b1, 1'b1);
    endtask

    // New search settings, then a batch of texts built mostly from keyword bytes
    task automatic run_random_phase();
        logic [7:0]          sym [3];
        logic [127:0]        key;
        logic [LEN_BITS-1:0] len;
        logic [HIT_BITS-1:0] limit;
        logic [7:0]          b;
        int                  nsym;
        bit                  spread;
        bit                  broken;
        int                  r;
        int                  kl;
        int                  n;
        int                  mark_pct;
        int                  plant;
        int                  target;
        int                  batch_items;

        for (int i = 0; i < 3; i++) begin
            sym[i] = ($urandom_range(0, 7) == 0) ? {8{1'($urandom)}} : 8'($urandom);
        end
        nsym   = $urandom_range(1, 3);
        spread = ($urandom_range(0, 3) == 0);
        for (int j = 0; j < MAX_KEYWORD; j++) begin
            key[8*j +: 8] = spread ? 8'($urandom) : sym[$urandom_range(0, nsym - 1)];
        end

        r = $urandom_range(0, 99);
        if (r < 5)       len = 0;
        else if (r < 10) len = LEN_BITS'($urandom_range(17, 31));
        else if (r < 22) len = 16;
        else if (r < 32) len = 1;
        else             len = LEN_BITS'($urandom_range(2, 15));
        r = $urandom_range(0, 99);
        if (r < 10)      limit = 0;
        else if (r < 35) limit = HIT_BITS'($urandom_range(1, 5));
        else if (r < 45) limit = 10'd1023;
        else             limit = HIT_BITS'($urandom_range(0, 1023));

        load_search_regs(len, limit, key, 1'b1);
        idle_on = ($urandom_range(0, 3) != 0);
        kl = (len >= 1 && len <= 16) ? int'(len) : $urandom_range(1, 4);
        target = $urandom_range(60, 160);
        batch_items = 0;

        while (batch_items < target) begin
            n = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 24) : $urandom_range(25, 120);
            case ($urandom_range(0, 3))
                0:       mark_pct = 0;
                1:       mark_pct = 10;
                2:       mark_pct = 40;
                default: mark_pct = 100;
            endcase
            broken = ($urandom_range(0, 9) == 0);
            plant  = -1;
            for (int i = 0; i < n; i++) begin
                if (plant < 0 && $urandom_range(0, 99) < 12) plant = 0;
                if (plant >= 0) begin
                    b = kw[plant];
                    plant++;
                    if (plant == kl) plant = -1;
                end else begin
                    b = ($urandom_range(0, 99) < 70) ? kw[$urandom_range(0, kl - 1)]
                                                     : 8'($urandom);
                end
                // Broken texts scatter the start and end flags at random
                push_text(b, $urandom_range(0, 99) < mark_pct,
                          broken ? ($urandom_range(0, 19) == 0) : (i == 0),
                          broken ? ($urandom_range(0, 19) == 0) : (i == n - 1));
            end
            batch_items += n;
        end
        random_items += batch_items;
    endtask

    initial begin
        i_rst_n               <= 1'b0;
        i_cfg_we              <= 1'b0;
        i_cfg_idx             <= CFG_KEY_LOW;
        i_cfg_data            <= '0;
        text_ch.valid         <= 1'b0;
        text_ch.text_byte     <= 8'd0;
        text_ch.page_begin    <= 1'b0;
        text_ch.first_of_text <= 1'b0;
        text_ch.last_of_text  <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        while (random_items < RUN_ITEMS) begin
            run_random_phase();
        end
        wait_drained();

        if (chk_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
